// ===== rtl/psnw_pkg.sv =====
// Shared constants and types for the point table nearest / window-count block.
`timescale 1ns / 1ps

package psnw_pkg;

   localparam int MAX_POINTS_DEF  = 256;
   localparam int COORD_BITS_DEF  = 24;
   localparam int WIN_BITS        = 16;
   localparam int KIND_W          = 2;

   localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd1800;

   // Item kinds carried on req_tuser
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   // Per-cell control: rotate the ring, or capture a new point
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== rtl/psnw_cell.sv =====
// One storage cell of the point ring: holds a point, passes it to its neighbor.
`timescale 1ns / 1ps

module psnw_cell #(
   parameter int COORD_BITS = psnw_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  psnw_pkg::cell_ctl_type       ctl,
   input  logic signed [COORD_BITS-1:0] load_x,
   input  logic signed [COORD_BITS-1:0] load_y,
   input  logic signed [COORD_BITS-1:0] link_x,
   input  logic signed [COORD_BITS-1:0] link_y,
   output logic signed [COORD_BITS-1:0] cell_x,
   output logic signed [COORD_BITS-1:0] cell_y
);
   import psnw_pkg::*;

   logic signed [COORD_BITS-1:0] x_ff;
   logic signed [COORD_BITS-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff <= load_x;
         y_ff <= load_y;
      end else if (ctl.shift) begin
         x_ff <= link_x;
         y_ff <= link_y;
      end
   end

   assign cell_x = x_ff;
   assign cell_y = y_ff;

endmodule

// ===== rtl/psnw_dist.sv =====
// Three-stage distance pipe: abs differences, squares and window test, sum.
`timescale 1ns / 1ps

module psnw_dist #(
   parameter int COORD_BITS = psnw_pkg::COORD_BITS_DEF,
   parameter int IDX_W      = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [IDX_W-1:0]                    in_idx,
   input  logic signed [COORD_BITS-1:0]        pt_x,
   input  logic signed [COORD_BITS-1:0]        pt_y,
   input  logic signed [COORD_BITS-1:0]        q_x,
   input  logic signed [COORD_BITS-1:0]        q_y,
   input  logic [psnw_pkg::WIN_BITS-1:0]       window_size,
   output logic                                out_valid,
   output logic [IDX_W-1:0]                    out_idx,
   output logic                                out_inwin,
   output logic [2*COORD_BITS:0]               out_dist,
   output logic                                busy
);
   import psnw_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int CMP_W = (C + 1 > WIN_BITS) ? C + 1 : WIN_BITS;

   logic [C:0]     dif_x, dif_y, neg_x, neg_y;
   logic [C-1:0]   s1_dx_in, s1_dy_in;

   logic           s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [C-1:0]   s1_dx_ff, s1_dy_ff;
   logic [2*C-1:0] s2_sqx_ff, s2_sqy_ff;
   logic           s2_inwin_ff, s3_inwin_ff;
   logic [2*C:0]   s3_dist_ff;
   logic           s2_inwin_in;

   // |a-b| fits in C bits: the widest span is 2^C - 1
   always_comb begin
      dif_x    = {pt_x[C-1], pt_x} - {q_x[C-1], q_x};
      dif_y    = {pt_y[C-1], pt_y} - {q_y[C-1], q_y};
      neg_x    = ~dif_x + 1'b1;
      neg_y    = ~dif_y + 1'b1;
      s1_dx_in = dif_x[C] ? neg_x[C-1:0] : dif_x[C-1:0];
      s1_dy_in = dif_y[C] ? neg_y[C-1:0] : dif_y[C-1:0];
      // strictly inside: 2*d < side on both axes
      s2_inwin_in = (CMP_W'({s1_dx_ff, 1'b0}) < CMP_W'(window_size)) &&
                    (CMP_W'({s1_dy_ff, 1'b0}) < CMP_W'(window_size));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_idx_ff   <= in_idx;
      s1_dx_ff    <= s1_dx_in;
      s1_dy_ff    <= s1_dy_in;
      s2_idx_ff   <= s1_idx_ff;
      s2_sqx_ff   <= {{C{1'b0}}, s1_dx_ff} * {{C{1'b0}}, s1_dx_ff};
      s2_sqy_ff   <= {{C{1'b0}}, s1_dy_ff} * {{C{1'b0}}, s1_dy_ff};
      s2_inwin_ff <= s2_inwin_in;
      s3_idx_ff   <= s2_idx_ff;
      s3_inwin_ff <= s2_inwin_ff;
      s3_dist_ff  <= {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   end

   assign out_valid = s3_valid_ff;
   assign out_idx   = s3_idx_ff;
   assign out_inwin = s3_inwin_ff;
   assign out_dist  = s3_dist_ff;
   assign busy      = s1_valid_ff | s2_valid_ff | s3_valid_ff;

endmodule

// ===== rtl/point_set_nearest_and_window_count.sv =====
// Top level: point table ring with nearest-point and window-count queries.
`timescale 1ns / 1ps
//
// Usage
//   req channel: one transaction per item. req_tuser holds the kind (clear,
//   insert, query, or the unused code which only reports status); req_tdata
//   holds pos_x then pos_y. rsp channel: exactly one transaction per item.
//   csr_wr_en / csr_wr_data set the window side; write only while idle.
// Latency / throughput
//   Clear, insert and the unused kind answer at the accepting edge: the
//   result is valid the next cycle, so these run at one item per cycle
//   while rsp_tready stays high. A query turns the ring of MAX_POINTS
//   cells once past a three stage distance pipe, waits for the pipe to
//   drain, then registers its result once the output register is free;
//   the next item is taken only after that result is registered.
// Reset
//   Synchronous, active high. Empties the table, resets the bounding box,
//   loads the default window side of 1800. Cell contents are not cleared.
// Backpressure
//   The result sits in an output register. A new item is taken while that
//   register is empty or being drained; a finished query waits in place
//   until the register frees up.

module point_set_nearest_and_window_count #(
   parameter int MAX_POINTS = psnw_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = psnw_pkg::COORD_BITS_DEF,
   localparam int IDX_W      = $clog2(MAX_POINTS),
   localparam int CNT_W      = $clog2(MAX_POINTS + 1),
   localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_RAW_W  = IDX_W + 2 * CNT_W + 2 + 4 * COORD_BITS,
   localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [psnw_pkg::WIN_BITS-1:0]    csr_wr_data,   // window_size
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [IN_DATA_W-1:0]             req_tdata,     // pos_x, pos_y
   input  logic [psnw_pkg::KIND_W-1:0]      req_tuser,     // kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // nearest_index, nearest_found, window_count, point_count,
   // insert_dropped, min_x, max_x, min_y, max_y
   output logic [OUT_DATA_W-1:0]            rsp_tdata
);
   import psnw_pkg::*;

   localparam int C = COORD_BITS;
   localparam logic signed [C-1:0] COORD_HI = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] COORD_LO = {1'b1, {(C-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [WIN_BITS-1:0]   win_size_ff, win_size_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic signed [C-1:0]   min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [C-1:0]   min_x_in, max_x_in, min_y_in, max_y_in;
   logic signed [C-1:0]   qx_ff, qy_ff, qx_in, qy_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [2*C:0]          best_ff, best_in;
   logic [IDX_W-1:0]      near_ff, near_in;
   logic                  found_ff, found_in;
   logic [CNT_W-1:0]      wcnt_ff, wcnt_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_RAW_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                  req_accept, out_free, ins_load, ring_shift;
   logic signed [C-1:0]   req_x, req_y;
   logic [KIND_W-1:0]     req_kind;

   logic signed [C-1:0]   cell_x [MAX_POINTS];
   logic signed [C-1:0]   cell_y [MAX_POINTS];
   cell_ctl_type          cell_ctl [MAX_POINTS];

   logic                  d_valid, d_inwin, d_busy;
   logic [IDX_W-1:0]      d_idx;
   logic [2*C:0]          d_dist;

   assign req_x      = req_tdata[C-1:0];
   assign req_y      = req_tdata[2*C-1:C];
   assign req_kind   = req_tuser;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign ins_load   = req_accept && (req_kind == KIND_INSERT) &&
                       (count_ff < CNT_W'(MAX_POINTS));
   assign ring_shift = (state_ff == ST_SCAN);

   // Ring of cells: cell k hands its point to cell k-1, cell 0 wraps to the
   // top. One full turn puts entry i at cell 0 on scan step i.
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
      assign cell_ctl[k] = '{shift: ring_shift,
                             load:  ins_load && (count_ff == CNT_W'(k))};
      psnw_cell #(
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock  (clock),
         .ctl    (cell_ctl[k]),
         .load_x (req_x),
         .load_y (req_y),
         .link_x (cell_x[(k + 1) % MAX_POINTS]),
         .link_y (cell_y[(k + 1) % MAX_POINTS]),
         .cell_x (cell_x[k]),
         .cell_y (cell_y[k])
      );
   end

   psnw_dist #(
      .COORD_BITS(COORD_BITS),
      .IDX_W     (IDX_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (ring_shift && (step_ff < count_ff)),
      .in_idx      (step_ff[IDX_W-1:0]),
      .pt_x        (cell_x[0]),
      .pt_y        (cell_y[0]),
      .q_x         (qx_ff),
      .q_y         (qy_ff),
      .window_size (win_size_ff),
      .out_valid   (d_valid),
      .out_idx     (d_idx),
      .out_inwin   (d_inwin),
      .out_dist    (d_dist),
      .busy        (d_busy)
   );

   always_comb begin
      state_in      = state_ff;
      win_size_in   = csr_wr_en ? csr_wr_data : win_size_ff;
      count_in      = count_ff;
      min_x_in      = min_x_ff;
      max_x_in      = max_x_ff;
      min_y_in      = min_y_ff;
      max_y_in      = max_y_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      step_in       = step_ff;
      best_in       = best_ff;
      near_in       = near_ff;
      found_in      = found_ff;
      wcnt_in       = wcnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                     min_x_in = COORD_HI;
                     min_y_in = COORD_HI;
                     max_x_in = COORD_LO;
                     max_y_in = COORD_LO;
                  end
                  KIND_INSERT: begin
                     if (ins_load) begin
                        count_in = count_ff + 1'b1;
                        if (req_x < min_x_ff) min_x_in = req_x;
                        if (req_x > max_x_ff) max_x_in = req_x;
                        if (req_y < min_y_ff) min_y_in = req_y;
                        if (req_y > max_y_ff) max_y_in = req_y;
                     end
                  end
                  default: begin
                  end
               endcase
               if (req_kind == KIND_QUERY) begin
                  qx_in    = req_x;
                  qy_in    = req_y;
                  step_in  = '0;
                  best_in  = '0;
                  near_in  = '0;
                  found_in = 1'b0;
                  wcnt_in  = '0;
                  state_in = ST_SCAN;
               end else begin
                  rsp_tvalid_in = 1'b1;
                  rsp_data_in   = {max_y_in, min_y_in, max_x_in, min_x_in,
                                   (req_kind == KIND_INSERT) && !ins_load,
                                   count_in, {CNT_W{1'b0}}, 1'b0, {IDX_W{1'b0}}};
               end
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(MAX_POINTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!d_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {max_y_ff, min_y_ff, max_x_ff, min_x_ff, 1'b0,
                                count_ff, wcnt_ff, found_ff, near_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // accumulate pipe results; strict less-than keeps the lowest index
      if (d_valid) begin
         if (!found_ff || (d_dist < best_ff)) begin
            best_in  = d_dist;
            near_in  = d_idx;
            found_in = 1'b1;
         end
         if (d_inwin) begin
            wcnt_in = wcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         win_size_ff   <= WIN_RESET;
         count_ff      <= '0;
         min_x_ff      <= COORD_HI;
         min_y_ff      <= COORD_HI;
         max_x_ff      <= COORD_LO;
         max_y_ff      <= COORD_LO;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         wcnt_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         win_size_ff   <= win_size_in;
         count_ff      <= count_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         wcnt_ff       <= wcnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      best_ff     <= best_in;
      near_ff     <= near_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OUT_DATA_W'(rsp_data_ff);

endmodule
